>>> sv/smta_pkg.sv
// Package for the sliding median threshold alert unit.
// Holds the sequencer state type and the fixed field widths and constants.
// No dependencies.
`default_nettype none

package smta_pkg;

  localparam int unsigned SampleW   = 8;
  localparam int unsigned LenW      = 9;
  localparam int unsigned CountW    = 9;
  localparam int unsigned MedW      = 9;
  localparam int unsigned AlertCntW = 32;

  localparam logic [LenW-1:0]      LenReset    = 9'd5;
  localparam logic [CountW-1:0]    CountMax    = '1;
  localparam logic [AlertCntW-1:0] AlertCntMax = '1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_RESULT,
    ST_OLD_RD,
    ST_DEC_RD,
    ST_DEC_WR,
    ST_INC_RD,
    ST_INC_WR
  } smta_state_e;

endpackage

`default_nettype wire

>>> sv/smta_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the histogram and the sample delay line. No dependencies.
`default_nettype none

module smta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/sliding_median_threshold_alert_unit.sv
// Sliding-window median alert: histogram RAM, delay-line RAM and a small sequencer.
// Depends on smta_pkg and smta_ram.
//
// Each sample is compared with twice the median of the last window_length samples once
// the window is full. The median comes from one pass over all VALUE_BINS histogram
// bins through a single accumulate-and-compare unit, one bin per cycle. An item that
// gives a result then steps through SCAN_END, RESULT, OLD_RD, DEC_RD, DEC_WR, INC_RD
// and INC_WR; an item taken while the window is still filling goes only through INC_RD
// and INC_WR and gives no result. The result step also waits for as long as an earlier
// result is still held by out_stall_i. After reset and after every window_length write
// the histogram is cleared one bin per cycle, during which no item is accepted.
`default_nettype none

module sliding_median_threshold_alert_unit #(
  parameter int unsigned VALUE_BINS = 256,
  parameter int unsigned WINDOW_MAX = 256
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [smta_pkg::LenW-1:0]         window_length_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [smta_pkg::SampleW-1:0]      sample_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [smta_pkg::MedW-1:0]         median_times_two_o,
  output logic                                   alert_o,
  output logic      [smta_pkg::AlertCntW-1:0]    alert_count_o
);

  localparam int unsigned BinW  = $clog2(VALUE_BINS);
  localparam int unsigned PtrW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned PlW   = (PtrW > smta_pkg::LenW) ? PtrW : smta_pkg::LenW;
  localparam int unsigned SumW  = smta_pkg::CountW + BinW;
  localparam int unsigned Med2W = BinW + 1;
  localparam int unsigned CmpW  = ((BinW > smta_pkg::SampleW) ? BinW : smta_pkg::SampleW) + 1;
  localparam logic [BinW-1:0] LastBin = BinW'(VALUE_BINS - 1);

  smta_pkg::smta_state_e state_q, state_d;

  logic [smta_pkg::LenW-1:0]      wl_q;
  logic [smta_pkg::LenW-1:0]      len_w;
  logic [smta_pkg::LenW-1:0]      rank_lo, rank_hi;
  logic [PtrW-1:0]                ptr_q;
  logic [smta_pkg::LenW-1:0]      fill_q;
  logic [BinW-1:0]                addr_q;
  logic [smta_pkg::SampleW-1:0]   sample_q;
  logic [BinW-1:0]                bin_q, old_bin_q;
  logic [SumW-1:0]                sum_q, sum_n;
  logic [BinW-1:0]                s1_q, s2_q, rd_bin_q;
  logic                           f1_q, f2_q, rd_vld_q;
  logic [Med2W-1:0]               med2;
  logic                           alert_w;
  logic [smta_pkg::AlertCntW-1:0] cnt_q;
  logic                           out_valid_q;
  logic                           accept, full_w, out_free, last_addr;
  logic [PlW-1:0]                 ptr_inc;

  logic                           hist_we, scan_rd, win_we;
  logic [BinW-1:0]                hist_waddr, hist_raddr, old_bin_w, sample_bin;
  logic [smta_pkg::CountW-1:0]    hist_wdata, hist_rdata;
  logic [smta_pkg::SampleW-1:0]   win_rdata;

  function automatic logic [BinW-1:0] to_bin(input logic [smta_pkg::SampleW-1:0] s);
    logic [BinW-1:0] b;
    if (CmpW'(s) >= CmpW'(VALUE_BINS)) begin
      b = LastBin;
    end else begin
      b = BinW'(s);
    end
    return b;
  endfunction

  always_comb begin
    if (wl_q == '0) begin
      len_w = smta_pkg::LenW'(1);
    end else if (32'(wl_q) > 32'(WINDOW_MAX)) begin
      len_w = smta_pkg::LenW'(WINDOW_MAX);
    end else begin
      len_w = wl_q;
    end
  end

  assign rank_hi    = (len_w >> 1) + smta_pkg::LenW'(1);
  assign rank_lo    = len_w[0] ? rank_hi : (len_w >> 1);
  assign accept     = in_valid_i && !in_stall_o;
  assign full_w     = fill_q >= len_w;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_addr  = addr_q == LastBin;
  assign ptr_inc    = PlW'(ptr_q) + PlW'(1);
  assign sum_n      = sum_q + SumW'(hist_rdata);
  assign med2       = Med2W'(s1_q) + Med2W'(s2_q);
  assign alert_w    = CmpW'(sample_q) >= CmpW'(med2);
  assign old_bin_w  = to_bin(win_rdata);
  assign sample_bin = to_bin(sample_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      smta_pkg::ST_CLEAR:    if (last_addr) state_d = smta_pkg::ST_IDLE;
      smta_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = full_w ? smta_pkg::ST_SCAN : smta_pkg::ST_INC_RD;
        end
      end
      smta_pkg::ST_SCAN:     if (last_addr) state_d = smta_pkg::ST_SCAN_END;
      smta_pkg::ST_SCAN_END: state_d = smta_pkg::ST_RESULT;
      smta_pkg::ST_RESULT:   if (out_free) state_d = smta_pkg::ST_OLD_RD;
      smta_pkg::ST_OLD_RD:   state_d = smta_pkg::ST_DEC_RD;
      smta_pkg::ST_DEC_RD:   state_d = smta_pkg::ST_DEC_WR;
      smta_pkg::ST_DEC_WR:   state_d = smta_pkg::ST_INC_RD;
      smta_pkg::ST_INC_RD:   state_d = smta_pkg::ST_INC_WR;
      smta_pkg::ST_INC_WR:   state_d = smta_pkg::ST_IDLE;
      default:               state_d = smta_pkg::ST_CLEAR;
    endcase
    if (cfg_we_i) begin
      state_d = smta_pkg::ST_CLEAR;
    end
  end

  always_comb begin
    in_stall_o = state_q != smta_pkg::ST_IDLE;
    hist_we    = 1'b0;
    hist_waddr = addr_q;
    hist_wdata = '0;
    hist_raddr = addr_q;
    scan_rd    = 1'b0;
    win_we     = 1'b0;
    case (state_q)
      smta_pkg::ST_CLEAR: begin
        hist_we = 1'b1;
      end
      smta_pkg::ST_SCAN: begin
        scan_rd = 1'b1;
      end
      smta_pkg::ST_DEC_RD: begin
        hist_raddr = old_bin_w;
      end
      smta_pkg::ST_DEC_WR: begin
        hist_we    = 1'b1;
        hist_waddr = old_bin_q;
        hist_wdata = (hist_rdata != '0) ? hist_rdata - smta_pkg::CountW'(1) : hist_rdata;
      end
      smta_pkg::ST_INC_RD: begin
        hist_raddr = bin_q;
      end
      smta_pkg::ST_INC_WR: begin
        hist_we    = 1'b1;
        hist_waddr = bin_q;
        hist_wdata = (hist_rdata != smta_pkg::CountMax) ?
                     hist_rdata + smta_pkg::CountW'(1) : hist_rdata;
        win_we     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smta_pkg::ST_CLEAR;
      wl_q        <= smta_pkg::LenReset;
      ptr_q       <= '0;
      fill_q      <= '0;
      addr_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      f1_q        <= 1'b0;
      f2_q        <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= scan_rd;
      if (state_q == smta_pkg::ST_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        wl_q   <= window_length_i;
        ptr_q  <= '0;
        fill_q <= '0;
        addr_q <= '0;
      end else begin
        case (state_q)
          smta_pkg::ST_CLEAR, smta_pkg::ST_SCAN: begin
            addr_q <= last_addr ? '0 : addr_q + BinW'(1);
          end
          smta_pkg::ST_IDLE: begin
            if (accept) begin
              addr_q <= '0;
              f1_q   <= 1'b0;
              f2_q   <= 1'b0;
              if (PlW'(ptr_q) >= PlW'(len_w)) begin
                ptr_q <= '0;
              end
            end
          end
          smta_pkg::ST_RESULT: begin
            if (out_free) begin
              if (alert_w && cnt_q != smta_pkg::AlertCntMax) begin
                cnt_q <= cnt_q + smta_pkg::AlertCntW'(1);
              end
            end
          end
          smta_pkg::ST_INC_WR: begin
            if (!full_w) begin
              fill_q <= fill_q + smta_pkg::LenW'(1);
            end
            ptr_q <= (ptr_inc >= PlW'(len_w)) ? '0 : PtrW'(ptr_inc);
          end
          default: begin
          end
        endcase
      end
      if (rd_vld_q) begin
        if (!f1_q && sum_n >= SumW'(rank_lo)) begin
          f1_q <= 1'b1;
        end
        if (!f2_q && sum_n >= SumW'(rank_hi)) begin
          f2_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_bin_q <= addr_q;
    if (accept) begin
      sample_q <= sample_i;
      bin_q    <= sample_bin;
      sum_q    <= '0;
      s1_q     <= '0;
      s2_q     <= '0;
    end
    if (rd_vld_q) begin
      sum_q <= sum_n;
      if (!f1_q && sum_n >= SumW'(rank_lo)) begin
        s1_q <= rd_bin_q;
      end
      if (!f2_q && sum_n >= SumW'(rank_hi)) begin
        s2_q <= rd_bin_q;
      end
    end
    if (state_q == smta_pkg::ST_DEC_RD) begin
      old_bin_q <= old_bin_w;
    end
    if (state_q == smta_pkg::ST_RESULT && out_free) begin
      median_times_two_o <= smta_pkg::MedW'(med2);
      alert_o            <= alert_w;
      alert_count_o      <= (alert_w && cnt_q != smta_pkg::AlertCntMax) ?
                            cnt_q + smta_pkg::AlertCntW'(1) : cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;

  smta_ram #(
    .WIDTH (smta_pkg::CountW),
    .DEPTH (VALUE_BINS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  smta_ram #(
    .WIDTH (smta_pkg::SampleW),
    .DEPTH (WINDOW_MAX)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (ptr_q),
    .wdata_i (sample_q),
    .raddr_i (ptr_q),
    .rdata_o (win_rdata)
  );

  a_result_after_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == smta_pkg::ST_RESULT))
    else $error("result raised outside the result step");

  a_no_hist_write_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == smta_pkg::ST_SCAN || state_q == smta_pkg::ST_SCAN_END) |-> !hist_we)
    else $error("histogram written during the median scan");

  a_fill_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= len_w)
    else $error("fill level beyond window length");

  a_ptr_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    PlW'(ptr_q) < PlW'(len_w))
    else $error("write pointer beyond window length");

  a_count_monotone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q >= $past(cnt_q))
    else $error("alert count decreased");

endmodule

`default_nettype wire

>>> tb/tb_sliding_median_threshold_alert_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sliding median threshold alert unit.
// It drives sample items and window length writes, and checks every result against a
// histogram model kept here. Depends on smta_pkg and the unit's RTL.
module tb_sliding_median_threshold_alert_unit;

  localparam int unsigned Bins     = 256;
  localparam int unsigned WinMax   = 256;
  localparam int unsigned DrainCyc = Bins + 16;
  localparam int unsigned Phases   = 9;

  localparam logic [smta_pkg::SampleW-1:0] Directed [25] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd254, 8'd1, 8'd128, 8'd127, 8'd2, 8'd4, 8'd8, 8'd16,
    8'd32, 8'd64, 8'd200, 8'd100, 8'd50
  };
  localparam logic [smta_pkg::LenW-1:0] PhaseLen [Phases] = '{
    9'd1, 9'd0, 9'd2, 9'd3, 9'd6, 9'd256, 9'd511, 9'd9, 9'd4
  };
  localparam int unsigned PhaseItems [Phases] = '{50, 40, 80, 80, 80, 280, 40, 100, 100};

  typedef struct packed {
    logic [smta_pkg::MedW-1:0]      med2;
    logic                           alert;
    logic [smta_pkg::AlertCntW-1:0] count;
  } alert_result_t;

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           cfg_we_i        = 1'b0;
  logic [smta_pkg::LenW-1:0]      window_length_i = '0;
  logic                           in_valid_i      = 1'b0;
  logic                           in_stall_o;
  logic [smta_pkg::SampleW-1:0]   sample_i        = '0;
  logic                           out_valid_o;
  logic                           out_stall_i     = 1'b0;
  logic [smta_pkg::MedW-1:0]      median_times_two_o;
  logic                           alert_o;
  logic [smta_pkg::AlertCntW-1:0] alert_count_o;

  sliding_median_threshold_alert_unit #(
    .VALUE_BINS(Bins),
    .WINDOW_MAX(WinMax)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .window_length_i    (window_length_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .sample_i           (sample_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .median_times_two_o (median_times_two_o),
    .alert_o            (alert_o),
    .alert_count_o      (alert_count_o)
  );

  always #6 clk_i = ~clk_i;

  logic [smta_pkg::CountW-1:0]    hist_q [Bins];
  logic [smta_pkg::SampleW-1:0]   line_q [WinMax];
  int unsigned                    wr_idx;
  int unsigned                    filled;
  logic [smta_pkg::AlertCntW-1:0] alert_total;
  logic [smta_pkg::LenW-1:0]      len_reg;

  alert_result_t                expected_alerts [$];
  logic [smta_pkg::SampleW-1:0] pending_samples [$];
  int unsigned                  samples_queued = 0;
  int unsigned                  samples_taken  = 0;
  int unsigned                  send_gap       = 0;
  int unsigned                  hold_left      = 0;
  bit                           steady         = 1'b0;
  bit                           failed         = 1'b0;

  function automatic void set_window(logic [smta_pkg::LenW-1:0] v);
    len_reg = v;
    foreach (hist_q[i]) hist_q[i] = '0;
    wr_idx = 0;
    filled = 0;
  endfunction

  function automatic int unsigned lowest_bin_at(int unsigned rank);
    int unsigned sum = 0;
    for (int unsigned b = 0; b < Bins; b++) begin
      sum += hist_q[b];
      if (sum >= rank) return b;
    end
    return 0;
  endfunction

  function automatic void take_sample(logic [smta_pkg::SampleW-1:0] s);
    int unsigned len;
    int unsigned med2;
    logic [smta_pkg::SampleW-1:0] gone;
    alert_result_t r;
    len = (len_reg == 0) ? 1 : ((len_reg > WinMax) ? WinMax : len_reg);
    if (wr_idx >= len) wr_idx = 0;
    if (filled >= len) begin
      if (len % 2 == 0) begin
        med2 = lowest_bin_at(len / 2) + lowest_bin_at(len / 2 + 1);
      end else begin
        med2 = 2 * lowest_bin_at(len / 2 + 1);
      end
      r.med2  = med2[smta_pkg::MedW-1:0];
      r.alert = (s >= med2);
      if (r.alert && alert_total != smta_pkg::AlertCntMax) alert_total++;
      r.count = alert_total;
      expected_alerts.insert(expected_alerts.size(), r);
      gone = line_q[wr_idx];
      if (hist_q[gone] != 0) hist_q[gone]--;
    end else begin
      filled++;
    end
    if (hist_q[s] != smta_pkg::CountMax) hist_q[s]++;
    line_q[wr_idx] = s;
    wr_idx = (wr_idx + 1 >= len) ? 0 : wr_idx + 1;
  endfunction

  // Values near a phase level, spikes near twice that level to provoke alerts, and random, extreme or small values.
  function automatic logic [smta_pkg::SampleW-1:0] draw_sample(int unsigned level);
    int unsigned pick;
    int unsigned v;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      v = level + $urandom_range(0, 8);
    end else if (pick < 55) begin
      v = 2 * level + $urandom_range(0, 8);
      if (v >= 4) v -= 4;
    end else if (pick < 70) begin
      v = $urandom_range(0, 255);
    end else if (pick < 80) begin
      v = ($urandom_range(0, 1) != 0) ? 255 : 0;
    end else begin
      v = $urandom_range(0, 7);
    end
    if (v > 255) v = 255;
    return v[smta_pkg::SampleW-1:0];
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  task automatic wait_idle();
    while (samples_taken != samples_queued || expected_alerts.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCyc) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive_proc
    logic presenting;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      presenting = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        take_sample(sample_i);
        samples_taken++;
        presenting = 1'b0;
      end
      if (!presenting && pending_samples.size() != 0) begin
        if (send_gap != 0) begin
          send_gap--;
        end else begin
          sample_i <= pending_samples.pop_front();
          presenting = 1'b1;
          send_gap = steady ? 0 : $urandom_range(0, 9);
        end
      end
      in_valid_i <= presenting;
    end
  end

  always @(posedge clk_i) begin : watch_proc
    alert_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_alerts.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0d %0d %0d", $time,
                   median_times_two_o, alert_o, alert_count_o);
          failed = 1'b1;
        end else begin
          want = expected_alerts.pop_front();
          check_field("median_times_two", 32'(want.med2), 32'(median_times_two_o));
          check_field("alert", 32'(want.alert), 32'(alert_o));
          check_field("alert_count", want.count, alert_count_o);
        end
        hold_left = steady ? 0 : $urandom_range(0, 9);
      end else if (out_valid_o && hold_left != 0) begin
        hold_left--;
      end
      out_stall_i <= (hold_left != 0);
    end
  end

  initial begin : run_proc
    int unsigned level;
    set_window(smta_pkg::LenReset);
    alert_total = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (Directed[i]) begin
      pending_samples.insert(pending_samples.size(), Directed[i]);
      samples_queued++;
    end
    wait_idle();
    for (int p = 0; p < Phases; p++) begin
      @(posedge clk_i);
      cfg_we_i        <= 1'b1;
      window_length_i <= PhaseLen[p];
      set_window(PhaseLen[p]);
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      steady = (p == 2) || ($urandom_range(0, 3) == 0);
      level  = (p % 3 == 0) ? $urandom_range(0, 3) : $urandom_range(0, 127);
      repeat (PhaseItems[p]) begin
        pending_samples.insert(pending_samples.size(), draw_sample(level));
        samples_queued++;
      end
      wait_idle();
    end
    if (!failed && expected_alerts.size() == 0) begin
      $display("sliding_median_threshold_alert_unit test passed");
    end else begin
      $display("sliding_median_threshold_alert_unit test failed");
    end
    $finish;
  end

  initial begin : limit_proc
    #20_000_000;
    $display("sliding_median_threshold_alert_unit test failed");
    $finish;
  end

endmodule

>>> sliding_median_threshold_alert_unit.f
sv/smta_pkg.sv
sv/smta_ram.sv
sv/sliding_median_threshold_alert_unit.sv
tb/tb_sliding_median_threshold_alert_unit.sv
